// ===== rtl/lpp_pkg.sv =====
// Package: shared widths, types and constants of the lens projection pipeline.
package lpp_pkg;

   localparam int IMAGE_WIDTH  = 640;
   localparam int IMAGE_HEIGHT = 480;
   localparam int COL_W        = $clog2(IMAGE_WIDTH);
   localparam int ROW_W        = $clog2(IMAGE_HEIGHT);

   localparam int PT_W    = 24;
   localparam int COEF_W  = 18;
   localparam int CAM_W   = 20;
   localparam int IDX_W   = 4;
   localparam int DEPTH_W = 16;

   localparam int ONE_Q16  = 65536;
   localparam int MM_PER_M = 1000;

   // divider: 40-bit magnitude numerator, 24-bit divisor, 21 quotient bits
   localparam int NUM_W = PT_W + 16;
   localparam int DEN_W = PT_W;
   localparam int QUO_W = 21;
   localparam int REM_W = DEN_W + QUO_W + 1;
   localparam int NORM_W = 22;

   typedef enum logic [IDX_W-1:0] {
      CSR_K1 = 4'd0,
      CSR_K2 = 4'd1,
      CSR_P1 = 4'd2,
      CSR_P2 = 4'd3,
      CSR_FX = 4'd4,
      CSR_FY = 4'd5,
      CSR_CX = 4'd6,
      CSR_CY = 4'd7
   } csr_idx_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] k1;
      logic signed [COEF_W-1:0] k2;
      logic signed [COEF_W-1:0] p1;
      logic signed [COEF_W-1:0] p2;
      logic [CAM_W-1:0]         fx;
      logic [CAM_W-1:0]         fy;
      logic [CAM_W-1:0]         cx;
      logic [CAM_W-1:0]         cy;
   } cfg_type;

   typedef struct packed {
      logic               nz;
      logic [DEPTH_W-1:0] depth;
      logic               negx;
      logic               negy;
   } meta_type;

   typedef struct packed {
      logic [REM_W-1:0] remx;
      logic [REM_W-1:0] remy;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] qx;
      logic [QUO_W-1:0] qy;
      logic             ovx;
      logic             ovy;
      meta_type         meta;
   } div_stage_type;

   typedef struct packed {
      logic [QUO_W-1:0] qx;
      logic [QUO_W-1:0] qy;
      logic             ovx;
      logic             ovy;
      meta_type         meta;
   } div_out_type;

   typedef struct packed {
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [DEPTH_W-1:0] depth;
      logic               in_image;
   } result_type;

endpackage

// ===== rtl/lpp_if.sv =====
// Interfaces: point input, pixel result and register write channels.
interface lpp_point_if import lpp_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic signed [PT_W-1:0] point_x;
   logic signed [PT_W-1:0] point_y;
   logic signed [PT_W-1:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface lpp_result_if import lpp_pkg::*;;
   logic               valid;
   logic               ready;
   logic [COL_W-1:0]   pixel_col;
   logic [ROW_W-1:0]   pixel_row;
   logic [DEPTH_W-1:0] depth_mm;
   logic               in_image;
   modport source (output valid, pixel_col, pixel_row, depth_mm, in_image, input ready);
   modport sink   (input valid, pixel_col, pixel_row, depth_mm, in_image, output ready);
endinterface

interface lpp_csr_if import lpp_pkg::*;;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [CAM_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lpp_csr.sv =====
// Register file for distortion coefficients and camera intrinsics.
module lpp_csr import lpp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   lpp_csr_if.sink   csr_bus,
   output cfg_type   cfg
);

   cfg_type cfg_ff;

   assign csr_bus.ready = 1'b1;
   assign cfg           = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.k1 <= '0;
         cfg_ff.k2 <= '0;
         cfg_ff.p1 <= '0;
         cfg_ff.p2 <= '0;
         cfg_ff.fx <= CAM_W'(133120);
         cfg_ff.fy <= CAM_W'(133120);
         cfg_ff.cx <= CAM_W'(81920);
         cfg_ff.cy <= CAM_W'(61440);
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_K1:  cfg_ff.k1 <= csr_bus.data[COEF_W-1:0];
            CSR_K2:  cfg_ff.k2 <= csr_bus.data[COEF_W-1:0];
            CSR_P1:  cfg_ff.p1 <= csr_bus.data[COEF_W-1:0];
            CSR_P2:  cfg_ff.p2 <= csr_bus.data[COEF_W-1:0];
            CSR_FX:  cfg_ff.fx <= csr_bus.data;
            CSR_FY:  cfg_ff.fy <= csr_bus.data;
            CSR_CX:  cfg_ff.cx <= csr_bus.data;
            CSR_CY:  cfg_ff.cy <= csr_bus.data;
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/lpp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes (x and y).
module lpp_div import lpp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num_x,
   input  logic [NUM_W-1:0]  num_y,
   input  logic [DEN_W-1:0]  den,
   input  meta_type          meta,
   output logic              out_valid,
   output div_out_type       out
);

   div_stage_type st_ff [0:QUO_W];
   div_stage_type st_in [0:QUO_W];
   logic          vld_ff [0:QUO_W];

   // entry stage: quotient at or above 2^21 means saturation
   always_comb begin
      st_in[0].remx = REM_W'(num_x);
      st_in[0].remy = REM_W'(num_y);
      st_in[0].den  = den;
      st_in[0].qx   = '0;
      st_in[0].qy   = '0;
      st_in[0].ovx  = DEN_W'(num_x[NUM_W-1:QUO_W]) >= den;
      st_in[0].ovy  = DEN_W'(num_y[NUM_W-1:QUO_W]) >= den;
      st_in[0].meta = meta;
   end

   for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
      localparam int B = QUO_W - s;
      logic [REM_W-1:0] dsh;
      assign dsh = REM_W'(st_ff[s-1].den) << B;
      always_comb begin
         st_in[s] = st_ff[s-1];
         if (st_ff[s-1].remx >= dsh) begin
            st_in[s].remx  = st_ff[s-1].remx - dsh;
            st_in[s].qx[B] = 1'b1;
         end
         if (st_ff[s-1].remy >= dsh) begin
            st_in[s].remy  = st_ff[s-1].remy - dsh;
            st_in[s].qy[B] = 1'b1;
         end
      end
   end

   for (genvar s = 0; s <= QUO_W; s++) begin : g_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign out_valid = vld_ff[QUO_W];
   assign out.qx    = st_ff[QUO_W].qx;
   assign out.qy    = st_ff[QUO_W].qy;
   assign out.ovx   = st_ff[QUO_W].ovx;
   assign out.ovy   = st_ff[QUO_W].ovy;
   assign out.meta  = st_ff[QUO_W].meta;

endmodule

// ===== rtl/lpp_distort.sv =====
// Distortion, intrinsics and bounds pipeline: eight register stages.
module lpp_distort import lpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  div_out_type din,
   input  cfg_type     cfg,
   output logic        out_valid,
   output result_type  res
);

   localparam logic [QUO_W-1:0] LIMIT = QUO_W'(1 << 20);

   logic vld_ff [0:7];

   // A: saturated signed normalized coordinates
   logic signed [NORM_W-1:0] xa_ff, ya_ff, xa_in, ya_in;
   meta_type                 ma_ff;
   logic [QUO_W-1:0]         magx, magy;
   // B: squares and cross term
   logic signed [25:0]       xx_ff, yy_ff, xy_ff;
   logic signed [NORM_W-1:0] xb_ff, yb_ff;
   meta_type                 mb_ff;
   logic signed [43:0]       pxx, pyy, pxy;
   // C: radius terms
   logic signed [26:0]       r2_in, r2_ff, xy2_ff;
   logic signed [27:0]       r2px_ff, r2py_ff;
   logic signed [35:0]       r4_ff;
   logic signed [NORM_W-1:0] xc_ff, yc_ff;
   meta_type                 mc_ff;
   logic signed [53:0]       pr4;
   // D: coefficient products
   logic signed [29:0]       tk1_ff, tp1x_ff, tp2y_ff;
   logic signed [38:0]       tk2_ff;
   logic signed [30:0]       tp2x_ff, tp1y_ff;
   logic signed [NORM_W-1:0] xd4_ff, yd4_ff;
   meta_type                 md_ff;
   logic signed [44:0]       pk1, pp1x, pp2y;
   logic signed [53:0]       pk2;
   logic signed [45:0]       pp2x, pp1y;
   // E: radial gain and tangential sums
   logic signed [39:0]       dist_ff;
   logic signed [31:0]       tx_ff, ty_ff;
   logic signed [NORM_W-1:0] xe_ff, ye_ff;
   meta_type                 me_ff;
   // F: distorted coordinates
   logic signed [46:0]       xd_ff, yd_ff;
   meta_type                 mf_ff;
   logic signed [61:0]       pdx, pdy;
   // G: pixel coordinates, Q.8
   logic signed [52:0]       u_ff, v_ff;
   meta_type                 mg_ff;
   logic signed [67:0]       pu, pv;
   // H: output
   result_type               res_ff;
   logic                     ok;

   always_comb begin
      magx  = (din.ovx || din.qx > LIMIT) ? LIMIT : din.qx;
      magy  = (din.ovy || din.qy > LIMIT) ? LIMIT : din.qy;
      xa_in = din.meta.negx ? -$signed(NORM_W'(magx)) : $signed(NORM_W'(magx));
      ya_in = din.meta.negy ? -$signed(NORM_W'(magy)) : $signed(NORM_W'(magy));
   end

   assign pxx   = 44'(xa_ff) * 44'(xa_ff);
   assign pyy   = 44'(ya_ff) * 44'(ya_ff);
   assign pxy   = 44'(xa_ff) * 44'(ya_ff);
   assign r2_in = 27'(xx_ff) + 27'(yy_ff);
   assign pr4   = 54'(r2_in) * 54'(r2_in);
   assign pk1   = 45'(cfg.k1) * 45'(r2_ff);
   assign pk2   = 54'(cfg.k2) * 54'(r4_ff);
   assign pp1x  = 45'(cfg.p1) * 45'(xy2_ff);
   assign pp2x  = 46'(cfg.p2) * 46'(r2px_ff);
   assign pp1y  = 46'(cfg.p1) * 46'(r2py_ff);
   assign pp2y  = 45'(cfg.p2) * 45'(xy2_ff);
   assign pdx   = 62'(dist_ff) * 62'(xe_ff);
   assign pdy   = 62'(dist_ff) * 62'(ye_ff);
   assign pu    = 68'($signed({1'b0, cfg.fx})) * 68'(xd_ff);
   assign pv    = 68'($signed({1'b0, cfg.fy})) * 68'(yd_ff);

   assign ok = mg_ff.nz
             && !u_ff[52] && (u_ff < 53'(IMAGE_WIDTH * 256))
             && !v_ff[52] && (v_ff < 53'(IMAGE_HEIGHT * 256));

   always_ff @(posedge clock) begin
      if (adv) begin
         xa_ff <= xa_in;
         ya_ff <= ya_in;
         ma_ff <= din.meta;

         xx_ff <= pxx[41:16];
         yy_ff <= pyy[41:16];
         xy_ff <= pxy[41:16];
         xb_ff <= xa_ff;
         yb_ff <= ya_ff;
         mb_ff <= ma_ff;

         r2_ff   <= r2_in;
         xy2_ff  <= 27'(xy_ff) <<< 1;
         r2px_ff <= 28'(r2_in) + (28'(xx_ff) <<< 1);
         r2py_ff <= 28'(r2_in) + (28'(yy_ff) <<< 1);
         r4_ff   <= pr4[51:16];
         xc_ff   <= xb_ff;
         yc_ff   <= yb_ff;
         mc_ff   <= mb_ff;

         tk1_ff  <= pk1[44:15];
         tk2_ff  <= pk2[53:15];
         tp1x_ff <= pp1x[44:15];
         tp2x_ff <= pp2x[45:15];
         tp1y_ff <= pp1y[45:15];
         tp2y_ff <= pp2y[44:15];
         xd4_ff  <= xc_ff;
         yd4_ff  <= yc_ff;
         md_ff   <= mc_ff;

         dist_ff <= 40'(ONE_Q16) + 40'(tk1_ff) + 40'(tk2_ff);
         tx_ff   <= 32'(tp1x_ff) + 32'(tp2x_ff);
         ty_ff   <= 32'(tp1y_ff) + 32'(tp2y_ff);
         xe_ff   <= xd4_ff;
         ye_ff   <= yd4_ff;
         me_ff   <= md_ff;

         xd_ff <= 47'($signed(pdx[61:16])) + 47'(tx_ff);
         yd_ff <= 47'($signed(pdy[61:16])) + 47'(ty_ff);
         mf_ff <= me_ff;

         u_ff  <= 53'($signed(pu[67:16])) + 53'($signed({1'b0, cfg.cx}));
         v_ff  <= 53'($signed(pv[67:16])) + 53'($signed({1'b0, cfg.cy}));
         mg_ff <= mf_ff;

         res_ff.col      <= ok ? u_ff[COL_W+7:8] : '0;
         res_ff.row      <= ok ? v_ff[ROW_W+7:8] : '0;
         res_ff.depth    <= mg_ff.depth;
         res_ff.in_image <= ok;
      end
   end

   for (genvar s = 0; s < 8; s++) begin : g_vld
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= (s == 0) ? in_valid : vld_ff[(s == 0) ? 0 : s-1];
         end
      end
   end

   assign out_valid = vld_ff[7];
   assign res       = res_ff;

endmodule

// ===== rtl/lens_distortion_point_projection.sv =====
// Top level: camera-frame point to distorted pixel, depth and in-image flag.
// Pipeline: 22 divider stages and 8 distortion/intrinsics/bounds stages.
// Throughput: one beat per cycle; the whole pipeline advances together and
//   freezes while rsp holds a beat that is not taken.
// Reset: valid bits clear, registers load their defaults (no distortion,
//   f = 520.0, c = 320.0/240.0); no clearing pass, req ready next cycle.
module lens_distortion_point_projection import lpp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   lpp_point_if.sink     req_bus,
   lpp_result_if.source  rsp_bus,
   lpp_csr_if.sink       csr_bus
);

   cfg_type     cfg;
   logic        adv;
   logic        div_valid, dist_valid;
   div_out_type div_out;
   result_type  res;

   // front end: sign/magnitude split and depth in mm
   logic                  negx, negy, negz;
   logic [PT_W-1:0]       magx, magy, magz;
   logic [NUM_W-1:0]      numx, numy;
   logic signed [33:0]    pmm;
   logic [17:0]           dmm;
   meta_type              meta;

   // whole pipeline moves when the output slot is free or being drained
   assign adv           = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = adv;

   assign negx = req_bus.point_x[PT_W-1];
   assign negy = req_bus.point_y[PT_W-1];
   assign negz = req_bus.point_z[PT_W-1];
   assign magx = negx ? PT_W'(-req_bus.point_x) : req_bus.point_x;
   assign magy = negy ? PT_W'(-req_bus.point_y) : req_bus.point_y;
   assign magz = negz ? PT_W'(-req_bus.point_z) : req_bus.point_z;
   assign numx = {magx, 16'b0};
   assign numy = {magy, 16'b0};

   // floor(z*1000/2^16), only for positive z
   assign pmm = 34'(req_bus.point_z) * 34'(MM_PER_M);
   assign dmm = pmm[33:16];

   always_comb begin
      meta.nz   = (req_bus.point_z != '0);
      meta.negx = negx ^ negz;
      meta.negy = negy ^ negz;
      if (negz || !meta.nz) begin
         meta.depth = '0;
      end else if (dmm[17:16] != 2'b00) begin
         meta.depth = '1;
      end else begin
         meta.depth = dmm[15:0];
      end
   end

   lpp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   lpp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_bus.valid),
      .num_x     (numx),
      .num_y     (numy),
      .den       (magz),
      .meta      (meta),
      .out_valid (div_valid),
      .out       (div_out)
   );

   lpp_distort u_distort (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_valid),
      .din       (div_out),
      .cfg       (cfg),
      .out_valid (dist_valid),
      .res       (res)
   );

   assign rsp_bus.valid     = dist_valid;
   assign rsp_bus.pixel_col = res.col;
   assign rsp_bus.pixel_row = res.row;
   assign rsp_bus.depth_mm  = res.depth;
   assign rsp_bus.in_image  = res.in_image;

`ifndef SYNTHESIS
   a_off_image_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.in_image |-> rsp_bus.pixel_col == '0 && rsp_bus.pixel_row == '0)
      else $error("off-image beat with nonzero pixel");
   a_in_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.in_image |->
         rsp_bus.pixel_col < COL_W'(IMAGE_WIDTH) && rsp_bus.pixel_row < ROW_W'(IMAGE_HEIGHT))
      else $error("in-image beat outside image");
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |-> !rsp_bus.valid || rsp_bus.ready)
      else $error("req beat taken while pipeline stalled");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("rsp valid right after reset");
`endif

endmodule

// ===== verif/testbench.sv =====
// Testbench for the lens distortion point projection pipeline.
module testbench;
   import lpp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Drain wait after the last expected beat; covers the whole pipe.
   localparam int PIPE_LAT    = 40;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RAND_PER_PH = 150;
   localparam int NUM_PHASES  = 6;

   logic clock;
   logic reset;

   lpp_point_if  req_bus ();
   lpp_result_if rsp_bus ();
   lpp_csr_if    csr_bus ();

   lens_distortion_point_projection i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   // Directed row: a point, plus a hand-worked answer where one is obvious.
   typedef struct {
      logic signed [PT_W-1:0] x;
      logic signed [PT_W-1:0] y;
      logic signed [PT_W-1:0] z;
      bit                     typed;
      result_type             res;
   } point_row_type;

   cfg_type    cam_cfg;           // our copy of the camera registers
   result_type pixel_queue[$];    // results still owed by the pipeline
   int         mismatches;
   int         beats_in;
   int         beats_out;
   int         out_of_image;
   int         zero_depth;
   int         cycle_count = 0;
   bit         hold_rsp;

   // ------------------------------------------------------------------
   // Clock and reset
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats still owed",
                  cycle_count, pixel_queue.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor: bit-exact fixed-point projection
   // ------------------------------------------------------------------
   // floor(v / 2^s): arithmetic shift of a signed value floors
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp_norm(longint v);
      longint lim;
      lim = longint'(1) << 20;
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic result_type project_point(logic signed [PT_W-1:0] px,
                                                logic signed [PT_W-1:0] py,
                                                logic signed [PT_W-1:0] pz,
                                                cfg_type c);
      result_type r;
      longint x, y, z, k1, k2, p1, p2, d;
      longint xn, yn, xx, yy, xy2, r2, r4, gain, xd, yd, u, v;
      x  = px;
      y  = py;
      z  = pz;
      k1 = $signed(c.k1);
      k2 = $signed(c.k2);
      p1 = $signed(c.p1);
      p2 = $signed(c.p2);
      r  = '0;
      if (z > 0) begin
         d = floor_shift(z * MM_PER_M, 16);
         r.depth = (d > 65535) ? 16'hFFFF : DEPTH_W'(d);
      end
      if (z != 0) begin
         // signed division truncates toward zero
         xn   = clamp_norm((x * ONE_Q16) / z);
         yn   = clamp_norm((y * ONE_Q16) / z);
         xx   = floor_shift(xn * xn, 16);
         yy   = floor_shift(yn * yn, 16);
         xy2  = 2 * floor_shift(xn * yn, 16);
         r2   = xx + yy;
         r4   = floor_shift(r2 * r2, 16);
         gain = ONE_Q16 + floor_shift(k1 * r2, 15) + floor_shift(k2 * r4, 15);
         xd   = floor_shift(gain * xn, 16) + floor_shift(p1 * xy2, 15)
              + floor_shift(p2 * (r2 + 2 * xx), 15);
         yd   = floor_shift(gain * yn, 16) + floor_shift(p1 * (r2 + 2 * yy), 15)
              + floor_shift(p2 * xy2, 15);
         u    = floor_shift(longint'(c.fx) * xd, 16) + longint'(c.cx);
         v    = floor_shift(longint'(c.fy) * yd, 16) + longint'(c.cy);
         if (u >= 0 && u < IMAGE_WIDTH * 256 && v >= 0 && v < IMAGE_HEIGHT * 256) begin
            r.in_image = 1'b1;
            r.col      = COL_W'(u >>> 8);
            r.row      = ROW_W'(v >>> 8);
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Register writes; valid stays up between back-to-back writes, the
   // caller drops it once the whole set is in.
   // ------------------------------------------------------------------
   task automatic write_reg(logic [IDX_W-1:0] idx, logic [CAM_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      unique case (idx)
         CSR_K1: cam_cfg.k1 = data[COEF_W-1:0];
         CSR_K2: cam_cfg.k2 = data[COEF_W-1:0];
         CSR_P1: cam_cfg.p1 = data[COEF_W-1:0];
         CSR_P2: cam_cfg.p2 = data[COEF_W-1:0];
         CSR_FX: cam_cfg.fx = data;
         CSR_FY: cam_cfg.fy = data;
         CSR_CX: cam_cfg.cx = data;
         CSR_CY: cam_cfg.cy = data;
         default: ;   // out-of-range index: dropped by the block
      endcase
   endtask

   task automatic load_camera(logic [CAM_W-1:0] k1, logic [CAM_W-1:0] k2,
                              logic [CAM_W-1:0] p1, logic [CAM_W-1:0] p2,
                              logic [CAM_W-1:0] fx, logic [CAM_W-1:0] fy,
                              logic [CAM_W-1:0] cx, logic [CAM_W-1:0] cy);
      write_reg(CSR_K1, k1);
      write_reg(CSR_K2, k2);
      write_reg(CSR_P1, p1);
      write_reg(CSR_P2, p2);
      write_reg(CSR_FX, fx);
      write_reg(CSR_FY, fy);
      write_reg(CSR_CX, cx);
      write_reg(CSR_CY, cy);
   endtask

   // ------------------------------------------------------------------
   // Point sender: one beat, held until accepted. The expectation is
   // queued at the accepting edge.
   // ------------------------------------------------------------------
   int burst_left;

   task automatic send_point(logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                             logic signed [PT_W-1:0] z);
      int gap;
      if (burst_left == 0) begin
         // random idle gap, then a fresh burst (sometimes long, no gaps)
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(0, 7) == 0 ? $urandom_range(40, 80)
                                                : $urandom_range(1, 10);
      end
      burst_left--;
      req_bus.valid   <= 1'b1;
      req_bus.point_x <= x;
      req_bus.point_y <= y;
      req_bus.point_z <= z;
      do @(posedge clock); while (!req_bus.ready);
      pixel_queue.insert(pixel_queue.size(), project_point(x, y, z, cam_cfg));
      beats_in++;
   endtask

   // Let the pipe empty out before touching registers.
   task automatic drain_pipe();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (PIPE_LAT) @(posedge clock);
   endtask

   // Mostly plausible scene points; some zero/negative depth and raw noise.
   task automatic send_random_point();
      int     kind;
      longint z, x, y;
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         send_point(PT_W'($urandom), PT_W'($urandom), '0);
      end else if (kind < 22) begin
         send_point(PT_W'($urandom), PT_W'($urandom), PT_W'($urandom));
      end else begin
         z = $urandom_range(13000, 600000);
         if (kind < 27) z = -z;
         if (kind > 95) z = $urandom_range(1, 300);          // tiny depth
         x = longint'($urandom_range(0, 1600)) - 800;
         y = longint'($urandom_range(0, 1200)) - 600;
         // x/z around +-0.8, y/z around +-0.6
         x = (x * (z < 0 ? -z : z)) / 1000;
         y = (y * (z < 0 ? -z : z)) / 1000;
         send_point(PT_W'(x), PT_W'(y), PT_W'(z));
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: receiver stalls and the checker
   // ------------------------------------------------------------------
   int ready_pct;

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_pct     <= 100;
      end else begin
         // pick a new stall density from four levels, full speed included
         if (cycle_count % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: ready_pct <= 100;
               1: ready_pct <= 80;
               2: ready_pct <= 50;
               default: ready_pct <= 20;
            endcase
         end
         rsp_bus.ready <= !hold_rsp && ($urandom_range(0, 99) < ready_pct);
      end
   end

   // long hold-off so the pipe fills and back-pressures the sender
   initial begin
      hold_rsp = 1'b0;
      wait (beats_in >= 150);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (120) @(posedge clock);
      hold_rsp = 1'b0;
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beats_out++;
         if (pixel_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected rsp beat: col %0d row %0d depth %0d in %0b",
                        rsp_bus.pixel_col, rsp_bus.pixel_row, rsp_bus.depth_mm,
                        rsp_bus.in_image);
         end else begin
            want = pixel_queue.pop_front();
            if (!want.in_image) out_of_image++;
            if (want.depth == '0) zero_depth++;
            if (rsp_bus.pixel_col !== want.col || rsp_bus.pixel_row !== want.row ||
                rsp_bus.depth_mm !== want.depth || rsp_bus.in_image !== want.in_image) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp beat %0d: want col %0d row %0d depth %0d in %0b, got col %0d row %0d depth %0d in %0b",
                           beats_out, want.col, want.row, want.depth, want.in_image,
                           rsp_bus.pixel_col, rsp_bus.pixel_row, rsp_bus.depth_mm,
                           rsp_bus.in_image);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   point_row_type directed[$];

   function automatic point_row_type row_of(int x, int y, int z, bit typed,
                                            int col, int row, int depth, bit in_img);
      point_row_type e;
      e.x = PT_W'(x);
      e.y = PT_W'(y);
      e.z = PT_W'(z);
      e.typed = typed;
      e.res.col = COL_W'(col);
      e.res.row = ROW_W'(row);
      e.res.depth = DEPTH_W'(depth);
      e.res.in_image = in_img;
      return e;
   endfunction

   function automatic void add_row(int x, int y, int z, bit typed,
                                   int col, int row, int depth, bit in_img);
      directed.insert(directed.size(), row_of(x, y, z, typed, col, row, depth, in_img));
   endfunction

   initial begin
      logic [IDX_W-1:0] bad_idx;
      result_type       got;
      mismatches    = 0;
      beats_in      = 0;
      beats_out     = 0;
      out_of_image  = 0;
      zero_depth    = 0;
      burst_left    = 0;
      reset         = 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.point_x <= '0;
      req_bus.point_y <= '0;
      req_bus.point_z <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= '0;
      csr_bus.data    <= '0;
      // register defaults: no distortion, f = 520.0, c = (320.0, 240.0)
      cam_cfg = '{k1: '0, k2: '0, p1: '0, p2: '0,
                  fx: 20'd133120, fy: 20'd133120, cx: 20'd81920, cy: 20'd61440};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points at reset defaults. On-axis points land on the
      // principal point (320, 240).
      add_row(0, 0, 65536, 1, 320, 240, 1000, 1);       // 1 m on axis
      add_row(65536, 65536, 0, 1, 0, 0, 0, 0);          // zero depth
      add_row(-8388608, 8388607, 0, 1, 0, 0, 0, 0);     // zero depth, extremes
      add_row(0, 0, -65536, 1, 320, 240, 0, 1);         // negative depth
      add_row(0, 0, 8388607, 1, 320, 240, 65535, 1);    // depth saturates
      add_row(0, 0, -8388608, 1, 320, 240, 0, 1);       // most negative z
      add_row(8388607, 0, 1, 1, 0, 0, 0, 0);            // tiny z, +16 clamp
      add_row(-8388608, -8388608, 1, 1, 0, 0, 0, 0);    // tiny z, -16 clamp
      add_row(0, 0, 1, 1, 320, 240, 0, 1);              // tiny z on axis
      add_row(0, 0, 66, 1, 320, 240, 1, 1);             // first whole mm
      add_row(8388607, 8388607, 8388607, 0, 0, 0, 0, 0);
      add_row(-8388608, 8388607, -8388608, 0, 0, 0, 0, 0);
      add_row(40000, 30000, 65536, 0, 0, 0, 0, 0);       // right edge zone
      add_row(-40330, -30245, 65536, 0, 0, 0, 0, 0);     // left/top edge
      add_row(40330, 30245, 65536, 0, 0, 0, 0, 0);
      add_row(45000, 0, 65536, 0, 0, 0, 0, 0);           // just outside
      add_row(12345, -6789, 131072, 0, 0, 0, 0, 0);
      add_row(-1, -1, 3, 0, 0, 0, 0, 0);                 // truncation sign

      foreach (directed[i]) begin
         send_point(directed[i].x, directed[i].y, directed[i].z);
         // typed answers must also agree with the predictor
         got = pixel_queue[$];
         if (directed[i].typed && got !== directed[i].res) begin
            mismatches++;
            if (mismatches <= 10)
               $display("directed row %0d: want col %0d row %0d depth %0d in %0b, predicted col %0d row %0d depth %0d in %0b",
                        i, directed[i].res.col, directed[i].res.row,
                        directed[i].res.depth, directed[i].res.in_image,
                        got.col, got.row, got.depth, got.in_image);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         if (ph > 0) begin
            drain_pipe();
            case (ph)
               // mild barrel distortion, typical intrinsics
               1: load_camera(-20'sd9830, 20'd3277, 20'd65, -20'sd131, 20'd135000,
                              20'd134500, 20'd80000, 20'd62000);
               // coefficient and focal maxima, zero center
               2: load_camera(20'd131071, 20'd131071, 20'd131071, 20'd131071,
                              20'hFFFFF, 20'hFFFFF, 20'd0, 20'd0);
               // coefficient minima, zero focal, center at the top of range
               3: load_camera(20'h20000, 20'h20000, 20'h20000, 20'h20000,
                              20'd0, 20'd0, 20'hFFFFF, 20'hFFFFF);
               4: load_camera(CAM_W'($urandom), CAM_W'($urandom),
                              CAM_W'($urandom), CAM_W'($urandom),
                              CAM_W'($urandom_range(60000, 200000)),
                              CAM_W'($urandom_range(60000, 200000)),
                              CAM_W'($urandom_range(40000, 120000)),
                              CAM_W'($urandom_range(30000, 90000)));
               default: begin
                  load_camera(CAM_W'($urandom_range(0, 6000)), 20'h3F000, 20'h3FF00,
                              20'd200, 20'd133120, 20'd133120, 20'd81920, 20'd61440);
                  // writes past the last register must leave everything alone
                  bad_idx = IDX_W'(CSR_CY) + IDX_W'($urandom_range(1, 8));
                  write_reg(bad_idx, CAM_W'($urandom));
                  write_reg(bad_idx | IDX_W'(8), 20'd0);
               end
            endcase
            csr_bus.valid <= 1'b0;
            @(posedge clock);
         end
         repeat (RAND_PER_PH) send_random_point();
      end

      drain_pipe();
      $display("%0d points sent, %0d results checked (%0d outside image, %0d zero depth)",
               beats_in, beats_out, out_of_image, zero_depth);
      $display("%0d camera settings incl. coefficient and intrinsic extremes, %0d mismatches",
               NUM_PHASES, mismatches);
      if (mismatches == 0 && pixel_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lpp_pkg.sv
rtl/lpp_if.sv
rtl/lpp_csr.sv
rtl/lpp_div.sv
rtl/lpp_distort.sv
rtl/lens_distortion_point_projection.sv
verif/testbench.sv
